// ===== rtl/mxr_pkg.sv =====
// Shared types, register indexes and constant tables of the modulated X/Y rotator.
package mxr_pkg;

  typedef struct packed {
    logic               frame_start;
    logic signed [15:0] angle_cv;
    logic signed [15:0] speed_cv;
    logic signed [15:0] x_in;
    logic signed [15:0] y_in;
  } mxr_in_t;

  typedef struct packed {
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
  } mxr_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VMUL,
    ST_VSET,
    ST_SSET0,
    ST_SMUL,
    ST_SSET1,
    ST_SDIV,
    ST_PSET,
    ST_AMUL,
    ST_ASET,
    ST_ADIV,
    ST_CSET,
    ST_CORDIC,
    ST_CFIN,
    ST_ROT,
    ST_DONE
  } mxr_state_t;

  localparam logic [2:0] REG_BASE_ANGLE  = 3'd0;
  localparam logic [2:0] REG_ANGLE_GAIN  = 3'd1;
  localparam logic [2:0] REG_SPEED_BASE  = 3'd2;
  localparam logic [2:0] REG_SPEED_GAIN  = 3'd3;
  localparam logic [2:0] REG_SPEED_HIGH  = 3'd4;
  localparam logic [2:0] REG_PRE_OFFS    = 3'd5;
  localparam logic [2:0] REG_POST_OFFS   = 3'd6;

  localparam logic signed [25:0] C4_Q16      = 26'sd17145893;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [25:0] ATAN_TAB [16] = '{
    26'd4194304, 26'd2476042, 26'd1308273, 26'd664101, 26'd333339, 26'd166832,
    26'd83436, 26'd41720, 26'd20861, 26'd10430, 26'd5215, 26'd2608, 26'd1304,
    26'd652, 26'd326, 26'd163
  };

  localparam logic [63:0] ROOT_Q30 [12] = '{
    64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280436,
    64'd1097253708, 64'd1085434106, 64'd1079572136, 64'd1076653033,
    64'd1075196443, 64'd1074468888, 64'd1074105294, 64'd1073923544
  };

  // One entry of the 2^(i/2^bits) table in Q1.30, built from the root constants.
  function automatic logic [30:0] exp_entry(input int unsigned i, input int unsigned bits);
    logic [63:0] acc;
    acc = 64'd1 << 30;
    for (int unsigned k = 1; k <= 12; k++) begin
      if (k <= bits) begin
        if (((i >> (bits - k)) & 1) != 0) begin
          acc = (acc * ROOT_Q30[k-1] + (64'd1 << 29)) >> 30;
        end
      end
    end
    return acc[30:0];
  endfunction

endpackage

// ===== rtl/modulated_xy_rotator_top.sv =====
// Top level of the modulated X/Y rotator: serial sequencer, shift-add multiplier,
// restoring divider, CORDIC and bit-serial rotation.
//
// Input items arrive on in_valid/in_data and are taken when in_stall is low; the
// block stalls its input while it works on one item. Results leave on
// out_valid/out_data through an output register, so a new item is taken while a
// finished result still waits for the receiver.
// A channel item without frame_start goes from acceptance straight to CFIN,
// then through the MSB-first bit-serial rotation and DONE.
// A frame-start item first runs the frame update: a shift-add multiply for the
// velocity, a restoring divide for the phase step (preceded by a second
// multiply in high mode), another multiply and divide for the angle CV term
// and a 16-step CORDIC. All multiplies share one multiplier, both divides one
// divider. Configuration is written through cfg_we/cfg_index/cfg_wdata; the
// user must write it only while the block is idle, as the block does not
// enforce this. Unknown indexes are ignored.
// Synchronous reset clears the phase and angle, sets the identity rotation and
// clears the configuration registers and the output valid. While the receiver
// stalls, the result holds and the next item is computed but waits in DONE.
module modulated_xy_rotator_top #(
  parameter int SAMPLE_RATE_HZ = 48000,
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mxr_pkg::mxr_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output mxr_pkg::mxr_out_t out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_wdata
);
  import mxr_pkg::*;

  localparam int EXP_SIZE = 1 << EXP_TABLE_BITS;
  localparam logic [35:0] FS = 36'(SAMPLE_RATE_HZ);
  localparam logic [56:0] FS_HALF = 57'(SAMPLE_RATE_HZ / 2);
  localparam logic [35:0] ANG_DIV = 36'd10240;
  localparam logic [56:0] ANG_HALF = 57'd5120;

  // Configuration registers.
  logic signed [15:0] base_angle_r, angle_gain_r, speed_gain_r;
  logic signed [13:0] speed_base_r;
  logic               speed_high_r;
  logic [31:0]        pre_offs_r, post_offs_r;

  // Sequencer and frame state.
  mxr_state_t state_r, state_nxt;
  mxr_in_t    item_r, item_nxt;
  logic [31:0] phase_r, phase_nxt;
  logic [15:0] angle_r, angle_nxt;
  logic signed [15:0] cos_r, cos_nxt, sin_r, sin_nxt;
  logic signed [13:0] v_r, v_nxt;
  logic        neg_r, neg_nxt;
  logic [35:0] dstep_r, dstep_nxt;

  // Shift-add multiplier.
  logic [4:0]         mcnt_r, mcnt_nxt;
  logic signed [25:0] ma_r, ma_nxt;
  logic [31:0]        mb_r, mb_nxt;
  logic signed [57:0] macc_r, macc_nxt;

  // Restoring divider.
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic [56:0] dn_r, dn_nxt;
  logic [35:0] dd_r, dd_nxt;
  logic [35:0] drem_r, drem_nxt;

  // CORDIC.
  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [25:0] cz_r, cz_nxt;
  logic        cneg_r, cneg_nxt;
  logic [3:0]  ccnt_r, ccnt_nxt;

  // Bit-serial rotation.
  logic [16:0] xp_r, xp_nxt, yp_r, yp_nxt;
  logic signed [34:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [4:0]  rcnt_r, rcnt_nxt;

  logic     out_valid_r, out_valid_nxt;
  mxr_out_t out_data_r, out_data_nxt;

  logic [30:0] exp_rom [EXP_SIZE];

  for (genvar g = 0; g < EXP_SIZE; g++) begin : g_exp
    assign exp_rom[g] = exp_entry(g, EXP_TABLE_BITS);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // Datapath helpers.
  logic signed [57:0] m_term;
  logic signed [37:0] d_trial;
  logic               d_ge;
  logic signed [33:0] c_dx, c_dy;
  logic signed [25:0] c_at;
  logic signed [34:0] r_c, r_s, r_tcx, r_tsx, r_tcy, r_tsy, r_addx, r_addy;
  logic signed [31:0] v_sum;
  logic signed [17:0] v_wide;
  logic [13:0]        u_val;
  logic [2:0]         u_exp;
  logic [22:0]        f_sh;
  logic [EXP_TABLE_BITS-1:0] e_idx;
  logic [12:0]        v_mag;
  logic [38:0]        n_low;
  logic signed [31:0] a_prod;
  logic [30:0]        a_mag;
  logic [17:0]        a_term;
  logic [31:0]        ph_rnd;
  logic [15:0]        a_raw;
  logic               a_fold;
  logic [15:0]        a_fin;
  logic signed [33:0] cv_x, cv_y;
  logic signed [33:0] cq_x, cq_y;
  logic signed [18:0] q_x, q_y;
  logic signed [16:0] pre_x, pre_y;
  logic signed [34:0] ro_x, ro_y;
  logic signed [20:0] so_x, so_y;

  function automatic logic signed [15:0] clamp_q15(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sd32767;
    end else if (v < -19'sd32767) begin
      return -16'sd32767;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    if (v > 21'sd32767) begin
      return 16'sd32767;
    end else if (v < -21'sd32768) begin
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

  always_comb begin
    m_term  = mb_r[31] ? {{32{ma_r[25]}}, ma_r} : 58'sd0;
    d_trial = $signed({1'b0, drem_r, dn_r[56]});
    d_ge    = d_trial >= $signed({1'b0, dd_r});
    c_dx    = cy_r >>> ccnt_r;
    c_dy    = cx_r >>> ccnt_r;
    c_at    = $signed(ATAN_TAB[ccnt_r]);

    r_c    = 35'(cos_r);
    r_s    = 35'(sin_r);
    r_tcx  = xp_r[16] ? r_c : 35'sd0;
    r_tsx  = xp_r[16] ? r_s : 35'sd0;
    r_tcy  = yp_r[16] ? r_c : 35'sd0;
    r_tsy  = yp_r[16] ? r_s : 35'sd0;
    r_addx = r_tcx + r_tsy;
    r_addy = r_tcy - r_tsx;

    v_sum  = macc_r[31:0] + 32'sd16384;
    v_wide = 18'(speed_base_r) + 18'($signed(v_sum[31:15]));

    u_val = 14'(v_r + 14'sd6144);
    u_exp = u_val[13:11];
    f_sh  = 23'(u_val[10:0]) << EXP_TABLE_BITS;
    e_idx = f_sh[11 +: EXP_TABLE_BITS];
    v_mag = v_r[13] ? 13'(-v_r) : 13'(v_r);
    n_low = (39'(v_mag) << 26) - (39'(v_mag) << 22);

    a_prod = macc_r[31:0];
    a_mag  = a_prod[31] ? 31'(-a_prod) : 31'(a_prod);
    a_term = neg_r ? 18'(-dn_r[17:0]) : dn_r[17:0];
    ph_rnd = phase_r + 32'h8000;
    a_raw  = base_angle_r + a_term[15:0] + ph_rnd[31:16];
    a_fold = a_raw[15] ^ a_raw[14];
    a_fin  = a_fold ? {~a_raw[15], a_raw[14:0]} : a_raw;

    cv_x = cneg_r ? -cx_r : cx_r;
    cv_y = cneg_r ? -cy_r : cy_r;
    cq_x = cv_x + 34'sd16384;
    cq_y = cv_y + 34'sd16384;
    q_x  = cq_x[33:15];
    q_y  = cq_y[33:15];

    pre_x = 17'(item_r.x_in) + 17'($signed(pre_offs_r[15:0]));
    pre_y = 17'(item_r.y_in) + 17'($signed(pre_offs_r[31:16]));
    ro_x  = rx_r + 35'sd16384;
    ro_y  = ry_r + 35'sd16384;
    so_x  = 21'($signed(ro_x[34:15])) + 21'($signed(post_offs_r[15:0]));
    so_y  = 21'($signed(ro_y[34:15])) + 21'($signed(post_offs_r[31:16]));
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    phase_nxt = phase_r;
    angle_nxt = angle_r;
    cos_nxt = cos_r;
    sin_nxt = sin_r;
    v_nxt = v_r;
    neg_nxt = neg_r;
    dstep_nxt = dstep_r;
    mcnt_nxt = mcnt_r;
    ma_nxt = ma_r;
    mb_nxt = mb_r;
    macc_nxt = macc_r;
    dcnt_nxt = dcnt_r;
    dn_nxt = dn_r;
    dd_nxt = dd_r;
    drem_nxt = drem_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    cz_nxt = cz_r;
    cneg_nxt = cneg_r;
    ccnt_nxt = ccnt_r;
    xp_nxt = xp_r;
    yp_nxt = yp_r;
    rx_nxt = rx_r;
    ry_nxt = ry_r;
    rcnt_nxt = rcnt_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          item_nxt = in_data;
          if (in_data.frame_start) begin
            ma_nxt = 26'(speed_gain_r);
            mb_nxt = 32'(in_data.speed_cv);
            macc_nxt = '0;
            mcnt_nxt = '0;
            state_nxt = ST_VMUL;
          end else begin
            state_nxt = ST_CFIN;
            // Skip the CORDIC result update for plain channel items.
            cneg_nxt = 1'b0;
          end
        end
      end
      ST_VMUL, ST_SMUL, ST_AMUL: begin
        macc_nxt = (macc_r <<< 1) + ((mcnt_r == 5'd0) ? -m_term : m_term);
        mb_nxt = mb_r << 1;
        mcnt_nxt = mcnt_r + 5'd1;
        if (mcnt_r == 5'd31) begin
          case (state_r)
            ST_VMUL: state_nxt = ST_VSET;
            ST_SMUL: state_nxt = ST_SSET1;
            default: state_nxt = ST_ASET;
          endcase
        end
      end
      ST_VSET: begin
        if (v_wide > 18'sd6144) begin
          v_nxt = 14'sd6144;
        end else if (v_wide < -18'sd6144) begin
          v_nxt = -14'sd6144;
        end else begin
          v_nxt = v_wide[13:0];
        end
        state_nxt = ST_SSET0;
      end
      ST_SSET0: begin
        dcnt_nxt = '0;
        drem_nxt = '0;
        if (speed_high_r) begin
          ma_nxt = C4_Q16;
          mb_nxt = {1'b0, exp_rom[e_idx]};
          macc_nxt = '0;
          mcnt_nxt = '0;
          dstep_nxt = FS << (5'd17 - 5'(u_exp));
          neg_nxt = 1'b0;
          state_nxt = ST_SMUL;
        end else begin
          dn_nxt = 57'(n_low) + FS_HALF;
          dd_nxt = FS;
          neg_nxt = v_r[13];
          state_nxt = ST_SDIV;
        end
      end
      ST_SSET1: begin
        dn_nxt = 57'(macc_r) + 57'(dstep_r >> 1);
        dd_nxt = dstep_r;
        dcnt_nxt = '0;
        drem_nxt = '0;
        state_nxt = ST_SDIV;
      end
      ST_SDIV, ST_ADIV: begin
        drem_nxt = d_ge ? 36'(d_trial - $signed({1'b0, dd_r})) : 36'(d_trial);
        dn_nxt = {dn_r[55:0], d_ge};
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'd56) begin
          state_nxt = (state_r == ST_SDIV) ? ST_PSET : ST_CSET;
        end
      end
      ST_PSET: begin
        phase_nxt = phase_r + (neg_r ? -dn_r[31:0] : dn_r[31:0]);
        ma_nxt = 26'(angle_gain_r);
        mb_nxt = 32'(item_r.angle_cv);
        macc_nxt = '0;
        mcnt_nxt = '0;
        state_nxt = ST_AMUL;
      end
      ST_ASET: begin
        neg_nxt = a_prod[31];
        dn_nxt = 57'(a_mag) + ANG_HALF;
        dd_nxt = ANG_DIV;
        dcnt_nxt = '0;
        drem_nxt = '0;
        state_nxt = ST_ADIV;
      end
      ST_CSET: begin
        angle_nxt = a_raw;
        cneg_nxt = a_fold;
        cx_nxt = CORDIC_GAIN;
        cy_nxt = '0;
        cz_nxt = 26'($signed(a_fin)) <<< 9;
        ccnt_nxt = '0;
        state_nxt = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (!cz_r[25]) begin
          cx_nxt = cx_r - c_dx;
          cy_nxt = cy_r + c_dy;
          cz_nxt = cz_r - c_at;
        end else begin
          cx_nxt = cx_r + c_dx;
          cy_nxt = cy_r - c_dy;
          cz_nxt = cz_r + c_at;
        end
        ccnt_nxt = ccnt_r + 4'd1;
        if (ccnt_r == 4'd15) begin
          state_nxt = ST_CFIN;
        end
      end
      ST_CFIN: begin
        // Only a frame start has fresh CORDIC output to store.
        if (item_r.frame_start) begin
          cos_nxt = clamp_q15(q_x);
          sin_nxt = clamp_q15(q_y);
        end
        xp_nxt = pre_x;
        yp_nxt = pre_y;
        rx_nxt = '0;
        ry_nxt = '0;
        rcnt_nxt = '0;
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        // MSB first; the sign bit carries negative weight.
        rx_nxt = (rx_r <<< 1) + ((rcnt_r == 5'd0) ? -r_addx : r_addx);
        ry_nxt = (ry_r <<< 1) + ((rcnt_r == 5'd0) ? -r_addy : r_addy);
        xp_nxt = xp_r << 1;
        yp_nxt = yp_r << 1;
        rcnt_nxt = rcnt_r + 5'd1;
        if (rcnt_r == 5'd16) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.x_out = sat16(so_x);
          out_data_nxt.y_out = sat16(so_y);
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      phase_r <= '0;
      angle_r <= '0;
      cos_r <= 16'sh7FFF;
      sin_r <= '0;
      base_angle_r <= '0;
      angle_gain_r <= '0;
      speed_base_r <= '0;
      speed_gain_r <= '0;
      speed_high_r <= 1'b0;
      pre_offs_r <= '0;
      post_offs_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r <= phase_nxt;
      angle_r <= angle_nxt;
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_ANGLE: base_angle_r <= cfg_wdata[15:0];
          REG_ANGLE_GAIN: angle_gain_r <= cfg_wdata[15:0];
          REG_SPEED_BASE: speed_base_r <= cfg_wdata[13:0];
          REG_SPEED_GAIN: speed_gain_r <= cfg_wdata[15:0];
          REG_SPEED_HIGH: speed_high_r <= cfg_wdata[0];
          REG_PRE_OFFS:   pre_offs_r <= cfg_wdata;
          REG_POST_OFFS:  post_offs_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    v_r <= v_nxt;
    neg_r <= neg_nxt;
    dstep_r <= dstep_nxt;
    mcnt_r <= mcnt_nxt;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
    macc_r <= macc_nxt;
    dcnt_r <= dcnt_nxt;
    dn_r <= dn_nxt;
    dd_r <= dd_nxt;
    drem_r <= drem_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    cz_r <= cz_nxt;
    cneg_r <= cneg_nxt;
    ccnt_r <= ccnt_nxt;
    xp_r <= xp_nxt;
    yp_r <= yp_nxt;
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
    rcnt_r <= rcnt_nxt;
    out_data_r <= out_data_nxt;
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared outside the finishing state");

  a_cordic_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORDIC && ccnt_r == 4'd15) |=> (state_r == ST_CFIN))
    else $error("CORDIC did not hand over after sixteen steps");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_VMUL || state_r == ST_CFIN))
    else $error("accepted transaction did not start work");

endmodule

// ===== verif/mxr_checker.sv =====
// Scoreboard of the modulated X/Y rotator: predicts each result and compares it.
module mxr_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  mxr_pkg::mxr_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  mxr_pkg::mxr_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  output int                fail_count,
  output int                pending
);
  import mxr_pkg::*;

  localparam int RATE_HZ  = 48000;
  localparam int EXP_BITS = 8;
  localparam int EXP_SIZE = 1 << EXP_BITS;

  logic [15:0] base_angle, angle_gain, speed_gain;
  logic [13:0] speed_base;
  logic        high_mode;
  logic [31:0] pre_offs, post_offs;
  logic [31:0] spin_phase;
  logic [15:0] frame_angle;
  longint      frame_cos, frame_sin;
  longint      exp2_tab [EXP_SIZE];
  mxr_out_t    expected_q[$];

  assign pending = expected_q.size();

  function automatic longint round_div(longint n, longint d);
    longint mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint q30_to_q15(longint v);
    return clip((v + 16384) >>> 15, -32767, 32767);
  endfunction

  task automatic build_exp_table();
    longint acc;
    for (int i = 0; i < EXP_SIZE; i++) begin
      acc = longint'(1) << 30;
      for (int k = 1; k <= EXP_BITS; k++) begin
        if (((i >> (EXP_BITS - k)) & 1) != 0) begin
          acc = (acc * longint'(ROOT_Q30[k-1]) + (longint'(1) << 29)) >>> 30;
        end
      end
      exp2_tab[i] = acc;
    end
  endtask

  // Rotation by CORDIC after folding the angle into the right half plane.
  task automatic update_cos_sin(logic [15:0] ang);
    longint a, x, y, z, dx, dy;
    bit     flip;
    a = longint'($signed(ang));
    flip = 0;
    if (a >= 16384) begin
      a -= 32768;
      flip = 1;
    end else if (a < -16384) begin
      a += 32768;
      flip = 1;
    end
    z = a * 512;
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_TAB[i]);
      end
    end
    frame_cos = q30_to_q15(flip ? -x : x);
    frame_sin = q30_to_q15(flip ? -y : y);
  endtask

  task automatic advance_frame(mxr_in_t t);
    longint vel, u, e6, f, idx, d, p, step, cv_term;
    logic [31:0] ph;
    vel = longint'($signed(speed_base))
        + ((longint'(t.speed_cv) * longint'($signed(speed_gain)) + 16384) >>> 15);
    vel = clip(vel, -6144, 6144);
    if (high_mode) begin
      u = vel + 6144;
      e6 = u >> 11;
      f = u & 2047;
      idx = ((f << EXP_BITS) >> 11) & (EXP_SIZE - 1);
      d = longint'(RATE_HZ) << (17 - e6);
      p = longint'(C4_Q16) * exp2_tab[idx];
      step = (p + d / 2) / d;
    end else begin
      step = round_div(60 * vel * 1048576, RATE_HZ);
    end
    spin_phase = spin_phase + step[31:0];
    ph = (spin_phase + 32'h8000) >> 16;
    cv_term = round_div(longint'(t.angle_cv) * longint'($signed(angle_gain)), 10240);
    frame_angle = base_angle + cv_term[15:0] + ph[15:0];
    update_cos_sin(frame_angle);
  endtask

  task automatic rotate_item(mxr_in_t t, output mxr_out_t r);
    longint xp, yp, xo, yo;
    if (t.frame_start) advance_frame(t);
    xp = longint'(t.x_in) + longint'($signed(pre_offs[15:0]));
    yp = longint'(t.y_in) + longint'($signed(pre_offs[31:16]));
    xo = ((frame_cos * xp + frame_sin * yp + 16384) >>> 15)
       + longint'($signed(post_offs[15:0]));
    yo = ((frame_cos * yp - frame_sin * xp + 16384) >>> 15)
       + longint'($signed(post_offs[31:16]));
    xo = clip(xo, -32768, 32767);
    yo = clip(yo, -32768, 32767);
    r.x_out = xo[15:0];
    r.y_out = yo[15:0];
  endtask

  task automatic report(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch on %s: got %0d, expected %0d", field, $signed(got), $signed(want));
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    build_exp_table();
  end

  always @(posedge clk) begin
    mxr_out_t r;
    if (!rst_n) begin
      base_angle <= '0; angle_gain <= '0; speed_base <= '0; speed_gain <= '0;
      high_mode <= 1'b0; pre_offs <= '0; post_offs <= '0;
      spin_phase = '0;
      frame_angle = '0;
      frame_cos = 32767;
      frame_sin = 0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("result transaction with no expectation waiting");
          fail_count++;
        end else begin
          r = expected_q.pop_front();
          if (out_data.x_out !== r.x_out) report("x_out", out_data.x_out, r.x_out);
          if (out_data.y_out !== r.y_out) report("y_out", out_data.y_out, r.y_out);
        end
      end
      if (in_valid && !in_stall) begin
        rotate_item(in_data, r);
        expected_q.push_back(r);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_ANGLE: base_angle <= cfg_wdata[15:0];
          REG_ANGLE_GAIN: angle_gain <= cfg_wdata[15:0];
          REG_SPEED_BASE: speed_base <= cfg_wdata[13:0];
          REG_SPEED_GAIN: speed_gain <= cfg_wdata[15:0];
          REG_SPEED_HIGH: high_mode  <= cfg_wdata[0];
          REG_PRE_OFFS:   pre_offs   <= cfg_wdata;
          REG_POST_OFFS:  post_offs  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== verif/modulated_xy_rotator_top_tb.sv =====
// Stimulus and verdict for the modulated X/Y rotator, checked by mxr_checker.
module modulated_xy_rotator_top_tb;
  import mxr_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_stall, out_valid, out_stall;
  mxr_in_t     in_data;
  mxr_out_t    out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  int          fail_count, pending;
  bit          quiet, hold_req;
  int          idle_cycles;

  modulated_xy_rotator_top DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  mxr_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: random stalls, a long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 25);
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send(mxr_in_t t);
    if (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] ba, logic [31:0] ag, logic [31:0] sb,
                              logic [31:0] sg, logic [31:0] hm, logic [31:0] pre,
                              logic [31:0] post);
    logic [31:0] vals [7];
    vals = '{ba, ag, sb, sg, hm, pre, post};
    cfg_we <= 1'b1;
    for (int i = 0; i < 7; i++) begin
      cfg_index <= i[2:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    // Index 7 does not exist and must leave everything as it was.
    cfg_index <= 3'd7;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic mxr_in_t make_item(bit fs, int acv, int scv, int x, int y);
    mxr_in_t t;
    t.frame_start = fs;
    t.angle_cv = acv[15:0];
    t.speed_cv = scv[15:0];
    t.x_in = x[15:0];
    t.y_in = y[15:0];
    return t;
  endfunction

  function automatic mxr_in_t random_item();
    mxr_in_t t;
    t = mxr_in_t'({$urandom, $urandom, $urandom});
    t.frame_start = ($urandom_range(99) < 20);
    return t;
  endfunction

  task automatic random_phase(int n);
    program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < n; i++) send(random_item());
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    quiet = 0;
    hold_req = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Items before any frame start see the identity rotation.
    send(make_item(0, 0, 0, 32767, -32768));
    send(make_item(0, 0, 0, -32768, 32767));
    send(make_item(1, 32767, -32768, 1234, -4321));
    send(make_item(0, -32768, 32767, 0, 0));
    settle();

    // Half-turn angle with large offsets and saturating outputs.
    program_regs(32'hFFFF_8000, 0, 0, 0, 0, 32'h7FFF_8000, 32'h8000_7FFF);
    send(make_item(1, 0, 0, 32767, 32767));
    send(make_item(0, 0, 0, -32768, -32768));
    send(make_item(0, 0, 0, 100, -100));
    settle();

    // Extreme gains, top velocity in exponential mode.
    program_regs(32'h7FFF, 32'h7FFF, 6144, 32'h8000, 1, 0, 32'h0800_F800);
    send(make_item(1, 32767, -32768, 32767, -32768));
    send(make_item(1, -32768, 32767, 2048, 2048));
    send(make_item(1, -32768, -32768, -2048, 4096));
    send(make_item(0, 0, 0, 32767, 32767));
    settle();

    // Out-of-range speed bases, both extremes: high in linear, low in exponential mode.
    program_regs(0, 32'h8000, 32'h1FFF, 32'h7FFF, 0, 32'hFFFF_FFFF, 0);
    send(make_item(1, 32767, 32767, -1, 1));
    send(make_item(1, 0, 32767, 5000, -5000));
    settle();
    program_regs(32'h4000, 32'h8000, 32'h2000, 32'h7FFF, 1, 0, 0);
    send(make_item(1, 32767, -32768, 3000, 7000));
    send(make_item(1, -32768, 0, -7000, 3000));
    send(make_item(0, 0, 0, 32767, -32768));
    settle();

    // Receiver holds off while items keep coming, so the input stalls.
    program_regs(0, 32'h2000, 32'h3800, 32'h1000, 0, 0, 0);
    hold_req = 1;
    for (int i = 0; i < 40; i++) send(random_item());
    settle();

    // A stretch without idling on either side.
    quiet = 1;
    random_phase(60);
    quiet = 0;

    for (int p = 0; p < 6; p++) random_phase(55);

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mxr_pkg.sv
rtl/modulated_xy_rotator_top.sv
verif/mxr_checker.sv
verif/modulated_xy_rotator_top_tb.sv
